### hdl/cts_pkg.sv
// shared types and constants for the capped tournament selector
package cts_pkg;

    localparam int POP_W      = 9;
    localparam int LIMIT_W    = 3;
    localparam int COUNT_W    = 3;
    localparam int ENERGY_W   = 32;
    localparam int PICK_W     = 8;
    localparam int OUT_IDX_W  = 8;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [POP_W-1:0]   POP_RESET   = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_POP_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEL_LIMIT = 1'b1;

    typedef enum logic {
        OP_LOAD       = 1'b0,
        OP_TOURNAMENT = 1'b1
    } cts_op_t;

    typedef struct packed {
        logic [POP_W-1:0]   pop_size;
        logic [LIMIT_W-1:0] selection_limit;
    } cts_cfg_t;

endpackage

### hdl/cts_ram.sv
// simple dual-port ram with registered read data
module cts_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/cts_sequencer.sv
// probe, compare and count-update sequencer of the tournament selector
module cts_sequencer #(
    parameter int MAX_MEMBERS = 256,
    localparam int IDX_W = $clog2(MAX_MEMBERS)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cts_pkg::cts_cfg_t           cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [cts_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cts_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [cts_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                        cnt_we,
    output logic [IDX_W-1:0]            cnt_waddr,
    output logic [cts_pkg::COUNT_W-1:0] cnt_wdata,
    output logic [IDX_W-1:0]            cnt_raddr,
    input  logic [cts_pkg::COUNT_W-1:0] cnt_rdata,
    output logic                        en_we,
    output logic [IDX_W-1:0]            en_waddr,
    output logic [cts_pkg::ENERGY_W-1:0] en_wdata,
    output logic [IDX_W-1:0]            en_raddr,
    input  logic [cts_pkg::ENERGY_W-1:0] en_rdata
);

    import cts_pkg::*;

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
    localparam int CMP_W = (CNT_W > POP_W) ? CNT_W : POP_W;
    localparam logic [CMP_W-1:0] MAX_C  = CMP_W'(MAX_MEMBERS);
    localparam logic [IDX_W-1:0] LAST_A = IDX_W'(MAX_MEMBERS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_P1_RD, ST_P1_CHK, ST_P2_RD, ST_P2_CHK,
        ST_E1_RD, ST_E2_RD, ST_WR1, ST_WR2, ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_reg, clr_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [IDX_W-1:0]        m1_reg, m1_next;
    logic [IDX_W-1:0]        m2_reg, m2_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    logic [COUNT_W-1:0]      c1_reg, c1_next;
    logic [COUNT_W-1:0]      c2_reg, c2_next;
    logic                    ride_reg, ride_next;
    logic                    none_reg, none_next;
    logic [ENERGY_W-1:0]     e1_reg, e1_next;
    logic [IDX_W-1:0]        win_reg, win_next;
    logic                    mv_reg, mv_next;
    logic [M_TDATA_W-1:0]    md_reg, md_next;
    logic [M_TUSER_W-1:0]    mu_reg, mu_next;

    logic                    accept;
    logic [CMP_W-1:0]        pop_ext, n_ext, idx_ext, pick1_ext, pick2_ext;
    logic                    load_ok;
    logic [CNT_W-1:0]        steps_inc;
    logic                    capped;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] p1;
        p1 = CNT_W'(p) + CNT_W'(1);
        return (p1 >= n) ? '0 : p1[IDX_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = mv_reg;
    assign m_tdata   = md_reg;
    assign m_tuser   = mu_reg;

    assign pop_ext   = CMP_W'(cfg.pop_size);
    assign n_ext     = (pop_ext == '0) ? CMP_W'(1) : ((pop_ext > MAX_C) ? MAX_C : pop_ext);
    assign idx_ext   = CMP_W'(s_tdata[7:0]);
    assign pick1_ext = CMP_W'(s_tdata[47:40]);
    assign pick2_ext = CMP_W'(s_tdata[55:48]);
    assign load_ok   = (idx_ext < MAX_C);
    assign steps_inc = steps_reg + CNT_W'(1);
    assign capped    = (cnt_rdata >= cfg.selection_limit);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = clr_reg;
        cnt_wdata = '0;
        cnt_raddr = m1_reg;
        en_we     = 1'b0;
        en_waddr  = idx_ext[IDX_W-1:0];
        en_wdata  = s_tdata[39:8];
        en_raddr  = m1_reg;
        case (state_reg)
            ST_CLEAR: begin
                cnt_we = 1'b1;
            end
            ST_IDLE: begin
                if (accept && s_tuser == OP_LOAD && load_ok) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = idx_ext[IDX_W-1:0];
                    en_we     = 1'b1;
                end
            end
            ST_P2_RD: begin
                cnt_raddr = m2_reg;
            end
            ST_E2_RD: begin
                en_raddr = m2_reg;
            end
            ST_WR1: begin
                cnt_we    = 1'b1;
                cnt_waddr = m1_reg;
                cnt_wdata = ride_reg ? bump(bump(c1_reg)) : bump(c1_reg);
            end
            ST_WR2: begin
                cnt_we    = 1'b1;
                cnt_waddr = m2_reg;
                cnt_wdata = bump(c2_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        n_next     = n_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        steps_next = steps_reg;
        c1_next    = c1_reg;
        c2_next    = c2_reg;
        ride_next  = ride_reg;
        none_next  = none_reg;
        e1_next    = e1_reg;
        win_next   = win_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        mu_next    = mu_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_A) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && s_tuser == OP_TOURNAMENT) begin
                    n_next     = n_ext[CNT_W-1:0];
                    m1_next    = (pick1_ext < n_ext) ? pick1_ext[IDX_W-1:0] : '0;
                    m2_next    = (pick2_ext < n_ext) ? pick2_ext[IDX_W-1:0] : '0;
                    steps_next = '0;
                    ride_next  = 1'b0;
                    none_next  = 1'b0;
                    state_next = ST_P1_RD;
                end
            end
            ST_P1_RD: begin
                state_next = ST_P1_CHK;
            end
            ST_P1_CHK: begin
                if (!capped) begin
                    c1_next    = cnt_rdata;
                    steps_next = '0;
                    state_next = ST_P2_RD;
                end else begin
                    m1_next    = advance(m1_reg, n_reg);
                    steps_next = steps_inc;
                    if (steps_inc >= n_reg) begin
                        none_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_P1_RD;
                    end
                end
            end
            ST_P2_RD: begin
                state_next = ST_P2_CHK;
            end
            ST_P2_CHK: begin
                if (capped || m2_reg == m1_reg) begin
                    steps_next = steps_inc;
                    if (steps_inc >= n_reg) begin
                        m2_next    = m1_reg;
                        ride_next  = 1'b1;
                        state_next = ST_E1_RD;
                    end else begin
                        m2_next    = advance(m2_reg, n_reg);
                        state_next = ST_P2_RD;
                    end
                end else begin
                    c2_next    = cnt_rdata;
                    state_next = ST_E1_RD;
                end
            end
            ST_E1_RD: begin
                state_next = ST_E2_RD;
            end
            ST_E2_RD: begin
                e1_next    = en_rdata;
                state_next = ST_WR1;
            end
            ST_WR1: begin
                win_next   = ($signed(e1_reg) >= $signed(en_rdata)) ? m1_reg : m2_reg;
                state_next = ride_reg ? ST_DONE : ST_WR2;
            end
            ST_WR2: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    if (none_reg) begin
                        md_next = '0;
                        mu_next = 2'b10;
                    end else begin
                        md_next = {OUT_IDX_W'(m2_reg), OUT_IDX_W'(m1_reg), OUT_IDX_W'(win_reg)};
                        mu_next = {1'b0, ride_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        steps_reg <= steps_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        ride_reg  <= ride_next;
        none_reg  <= none_next;
        e1_reg    <= e1_next;
        win_reg   <= win_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

### hdl/capped_tournament_selector.sv
// top level of the capped binary tournament selector
//
// input beats on s_*: s_tuser is the opcode, load (0) or tournament (1)
// a load writes one member's energy and clears its use count, if its index
// is below MAX_MEMBERS; a tournament walks the use-count ram from each start
// index, reading and checking a count per probe step on its single read port,
// then reads both energies from the energy ram, compares them and writes back
// the counts; the search for each mate takes from 1 up to the pop size probe
// steps, and a free ride writes back only the first mate's count, bumped twice;
// with no free first mate the tournament ends with none_available and no write
// s_tready returns in the same cycle as the result
// s_tready is low while a tournament runs
// results leave through a register on m_*; a stalled receiver holds the
// result, loads keep flowing, and a finishing tournament waits for the slot
// after reset a clearing pass zeroes every entry of the count ram,
// with s_tready low; configuration writes are taken during the pass
module capped_tournament_selector #(
    parameter int MAX_MEMBERS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cts_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [cts_pkg::POP_W-1:0]       cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // load_index, energy, first_pick, second_pick
    input  logic [cts_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // winner_index, first_mate, second_mate
    output logic [cts_pkg::M_TDATA_W-1:0]   m_tdata,
    // free_ride, none_available
    output logic [cts_pkg::M_TUSER_W-1:0]   m_tuser
);

    import cts_pkg::*;

    localparam int IDX_W = $clog2(MAX_MEMBERS);

    cts_cfg_t             cfg_reg;
    logic                 cnt_we, en_we;
    logic [IDX_W-1:0]     cnt_waddr, cnt_raddr, en_waddr, en_raddr;
    logic [COUNT_W-1:0]   cnt_wdata, cnt_rdata;
    logic [ENERGY_W-1:0]  en_wdata, en_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pop_size        <= POP_RESET;
            cfg_reg.selection_limit <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_POP_SIZE:  cfg_reg.pop_size        <= cfg_wr_data;
                REG_SEL_LIMIT: cfg_reg.selection_limit <= cfg_wr_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cts_ram #(
        .DEPTH (MAX_MEMBERS),
        .WIDTH (COUNT_W)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    cts_ram #(
        .DEPTH (MAX_MEMBERS),
        .WIDTH (ENERGY_W)
    ) u_energy_ram (
        .aclk  (aclk),
        .we    (en_we),
        .waddr (en_waddr),
        .wdata (en_wdata),
        .raddr (en_raddr),
        .rdata (en_rdata)
    );

    cts_sequencer #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_sequencer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cnt_we    (cnt_we),
        .cnt_waddr (cnt_waddr),
        .cnt_wdata (cnt_wdata),
        .cnt_raddr (cnt_raddr),
        .cnt_rdata (cnt_rdata),
        .en_we     (en_we),
        .en_waddr  (en_waddr),
        .en_wdata  (en_wdata),
        .en_raddr  (en_raddr),
        .en_rdata  (en_rdata)
    );

    // count clearing pass runs right after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("input taken before count clear");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
        else $error("none_available beat carries data");

    a_ride_same: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[15:8] == m_tdata[23:16])
        else $error("free ride with distinct mates");

    a_winner_mate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |->
            (m_tdata[7:0] == m_tdata[15:8]) || (m_tdata[7:0] == m_tdata[23:16]))
        else $error("winner is neither mate");

endmodule
